FILE: rtl/running_median_peak_filter_macros.svh
// Assertion macros shared by the checker of the running median and peak filter.
// Depends on nothing; the including scope provides i_clk and i_rst_n.
`ifndef RUNNING_MEDIAN_PEAK_FILTER_MACROS_SVH
`define RUNNING_MEDIAN_PEAK_FILTER_MACROS_SVH

// Property checked at every edge outside reset.
`define RMPF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define RMPF_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/rmpf_pkg.sv
// Shared types for the running median and peak filter.
// Holds the link record passed between neighboring sorting cells; no dependencies.
`timescale 1ns / 1ps

package rmpf_pkg;

    // Control seen by a cell's neighbors.
    typedef struct packed {
        logic valid;  // cell holds a sample
        logic ev;     // entry after eviction is valid
        logic ge;     // entry after eviction is at least the new sample
        logic med;    // cell marks the median rank
    } t_link;

endpackage

FILE: rtl/rmpf_cell.sv
// One cell of the sorted chain: holds one sample and its median marker.
// Depends on rmpf_pkg for the link record exchanged with its neighbors.
`timescale 1ns / 1ps

module rmpf_cell #(
    parameter int       SAMPLE_BITS = 16,
    parameter bit       IS_HEAD     = 1'b0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic                          i_shift_med,
    input  logic                          i_full,
    input  logic signed [SAMPLE_BITS-1:0] i_x,
    input  logic signed [SAMPLE_BITS-1:0] i_oldest,
    input  rmpf_pkg::t_link               i_up,
    input  logic signed [SAMPLE_BITS-1:0] i_up_e,
    input  rmpf_pkg::t_link               i_dn,
    input  logic signed [SAMPLE_BITS-1:0] i_dn_s,
    output rmpf_pkg::t_link               o_link,
    output logic signed [SAMPLE_BITS-1:0] o_s,
    output logic signed [SAMPLE_BITS-1:0] o_e
);
    import rmpf_pkg::*;

    logic signed [SAMPLE_BITS-1:0] r_s;
    logic signed [SAMPLE_BITS-1:0] n_s;
    logic                          r_valid;
    logic                          n_valid;
    logic                          r_med;
    logic                          rm;
    logic                          ev;
    logic                          ge;
    logic signed [SAMPLE_BITS-1:0] e;

    // The evicted sample sits at the first entry not greater than it, so every
    // cell at or below that entry takes its lower neighbor's sample.
    assign rm = i_full && r_valid && (r_s <= i_oldest);
    assign e  = rm ? i_dn_s : r_s;
    assign ev = rm ? i_dn.valid : r_valid;
    assign ge = ev && (e >= i_x);

    always_comb begin
        if (ge) begin
            n_s     = e;
            n_valid = 1'b1;
        end else if (i_up.ge) begin
            n_s     = i_x;
            n_valid = 1'b1;
        end else begin
            n_s     = i_up_e;
            n_valid = i_up.ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_med   <= IS_HEAD;
        end else if (i_load) begin
            r_valid <= n_valid;
            if (i_shift_med) begin
                r_med <= i_up.med;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s <= n_s;
        end
    end

    assign o_link = '{valid: r_valid, ev: ev, ge: ge, med: r_med};
    assign o_s    = r_s;
    assign o_e    = e;

endmodule

FILE: rtl/running_median_peak_filter.sv
// Running median and peak filter over the last WINDOW signed samples. One item
// is taken per clock when the result side keeps up; the cells take up each item,
// and its result then moves into the output register. The rate is set by the
// chain of compare-and-shift cells, which evicts the oldest sample and inserts
// the new one in the same update. Depends on rmpf_pkg and rmpf_cell.
`timescale 1ns / 1ps

module running_median_peak_filter #(
    parameter int WINDOW      = 9,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0] o_median_value,
    output logic signed [SAMPLE_BITS-1:0] o_peak_value
);
    import rmpf_pkg::*;

    localparam logic signed [SAMPLE_BITS-1:0] MinVal = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam t_link HeadLink = '{valid: 1'b1, ev: 1'b1, ge: 1'b1, med: 1'b0};
    localparam t_link TailLink = '{valid: 1'b0, ev: 1'b0, ge: 1'b0, med: 1'b0};

    logic signed [SAMPLE_BITS-1:0] r_tap [WINDOW];
    logic                          r_odd;
    logic                          r_pend;
    logic                          r_ov;
    logic signed [SAMPLE_BITS-1:0] r_median;
    logic signed [SAMPLE_BITS-1:0] r_peak;
    logic signed [SAMPLE_BITS-1:0] n_median;

    logic signed [SAMPLE_BITS-1:0] x;
    logic                          load;
    logic                          full;
    logic                          shift_med;
    logic                          slot_free;
    logic                          move_out;

    t_link                         w_link [WINDOW];
    logic signed [SAMPLE_BITS-1:0] w_s    [WINDOW];
    logic signed [SAMPLE_BITS-1:0] w_e    [WINDOW];

    assign x         = (i_sample == MinVal) ?
                       MinVal + {{(SAMPLE_BITS-1){1'b0}}, 1'b1} : i_sample;
    assign slot_free = !r_ov || i_ready;
    assign move_out  = r_pend && slot_free;
    assign o_ready   = !r_pend || slot_free;
    assign load      = i_valid && o_ready;
    assign full      = w_link[WINDOW-1].valid;
    // The median rank moves down one cell each time the count becomes odd.
    assign shift_med = !full && w_link[0].valid && !r_odd;

    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        t_link                         up;
        t_link                         dn;
        logic signed [SAMPLE_BITS-1:0] up_e;
        logic signed [SAMPLE_BITS-1:0] dn_s;

        if (g == 0) begin : g_head
            assign up   = HeadLink;
            assign up_e = x;
        end else begin : g_mid
            assign up   = w_link[g-1];
            assign up_e = w_e[g-1];
        end

        if (g == WINDOW - 1) begin : g_tail
            assign dn   = TailLink;
            assign dn_s = x;
        end else begin : g_body
            assign dn   = w_link[g+1];
            assign dn_s = w_s[g+1];
        end

        rmpf_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .IS_HEAD     (g == 0)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_load      (load),
            .i_shift_med (shift_med),
            .i_full      (full),
            .i_x         (x),
            .i_oldest    (r_tap[WINDOW-1]),
            .i_up        (up),
            .i_up_e      (up_e),
            .i_dn        (dn),
            .i_dn_s      (dn_s),
            .o_link      (w_link[g]),
            .o_s         (w_s[g]),
            .o_e         (w_e[g])
        );
    end

    // Arrival-order line; its last tap is the sample to evict once full.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tap[0] <= x;
            for (int i = 1; i < WINDOW; i++) begin
                r_tap[i] <= r_tap[i-1];
            end
        end
    end

    always_comb begin
        n_median = '0;
        for (int i = 0; i < WINDOW; i++) begin
            n_median = n_median | (w_s[i] & {SAMPLE_BITS{w_link[i].med}});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_odd  <= 1'b0;
            r_pend <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            if (load && !full) begin
                r_odd <= !r_odd;
            end
            if (load) begin
                r_pend <= 1'b1;
            end else if (move_out) begin
                r_pend <= 1'b0;
            end
            if (move_out) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // The cells still hold the pending item's state at the edge that moves it out.
    always_ff @(posedge i_clk) begin
        if (move_out) begin
            r_median <= n_median;
            r_peak   <= w_s[0];
        end
    end

    assign o_valid        = r_ov;
    assign o_median_value = r_median;
    assign o_peak_value   = r_peak;

endmodule

FILE: rtl/rmpf_checker.sv
// Port-level checks for the running median and peak filter, bound to the top level.
// Depends on running_median_peak_filter_macros.svh for the assertion macros.
`timescale 1ns / 1ps

module rmpf_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic signed [SAMPLE_BITS-1:0] i_sample,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic signed [SAMPLE_BITS-1:0] o_median_value,
    input logic signed [SAMPLE_BITS-1:0] o_peak_value
);
`include "running_median_peak_filter_macros.svh"

    localparam logic signed [SAMPLE_BITS-1:0] MinVal = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // A waiting input item keeps its sample until it is taken.
    `RMPF_ASSERT(a_in_hold, (i_valid && !o_ready) |=> (i_valid && $stable(i_sample)), "input item changed while waiting")
    // A stalled result item keeps its values.
    `RMPF_ASSERT(a_hold, (o_valid && !i_ready) |=> (o_valid && $stable(o_median_value) && $stable(o_peak_value)), "result item changed while stalled")
    // The peak is the top of the window, so it never lies below the median.
    `RMPF_ASSERT(a_order, o_valid |-> (o_peak_value >= o_median_value), "peak below median")
    // The most negative sample is raised on entry and never comes out.
    `RMPF_ASSERT(a_no_min, o_valid |-> ((o_median_value != MinVal) && (o_peak_value != MinVal)), "minimum sentinel in result item")
    // Reset leaves no result item behind.
    `RMPF_ASSERT_RST(a_reset, (!i_rst_n) |=> !o_valid, "result item valid after reset")

endmodule

bind running_median_peak_filter rmpf_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_rmpf_checker (.*);
